### hdl/bis_pkg.sv
package bis_pkg;

    localparam int PIX_W = 8;
    localparam int REG_W = 10;
    localparam int NUM_REGS = 4;

    typedef enum logic [1:0] {
        REG_SRC_W = 2'd0,
        REG_SRC_H = 2'd1,
        REG_TGT_W = 2'd2,
        REG_TGT_H = 2'd3
    } reg_idx_t;

    typedef enum logic {
        CMD_WRITE   = 1'b0,
        CMD_COMPUTE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic       cmd;
        logic [8:0] pos_x;
        logic [8:0] pos_y;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVX,
        ST_DIVY,
        ST_ADDR,
        ST_RD,
        ST_WX,
        ST_MX,
        ST_WY,
        ST_MY,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } div_ctl_t;

endpackage

### hdl/bilinear_image_scaler_core.sv
// Bilinear image scaler. Source pixels are written with cmd 0 (no
// result); a compute word (cmd 1) returns one interpolated RGB word.
// A compute runs to completion before the next input word is taken.
// Each coordinate division runs on the shared bit-serial divider, and is
// skipped (coordinate zero) when that target dimension is one. The four
// neighbour reads from the single-port pixel memory each step through
// ST_ADDR and ST_RD. The blend steps through ST_WX, ST_MX, ST_WY, ST_MY
// and ST_SUM per neighbour through one weight multiplier and one
// channel multiplier per color. ST_OUT then loads the result register.
// in_ready is low while a compute is in flight, and also while a result
// waits in the output register and out_ready is low. The pixel memory has
// no reset: reading a pixel never written gives undefined data. Write config
// only while idle.
module bilinear_image_scaler_core #(
    parameter int MAX_DIM_X = 512,
    parameter int MAX_DIM_Y = 512,
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bis_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bis_pkg::out_word_t  out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [9:0]          cfg_data
);
    localparam int XB    = $clog2(MAX_DIM_X);
    localparam int YB    = $clog2(MAX_DIM_Y);
    localparam int CB    = (XB > YB) ? XB : YB;      // coordinate bits
    localparam int DB    = CB + 1;                   // dimension bits
    localparam int NUM_W = CB + FRAC_BITS + CB;
    localparam int AW    = XB + YB;
    localparam int DEPTH = 1 << AW;                  // {row, column} address space
    localparam int WW    = FRAC_BITS + 1;            // weight width (one incl.)
    localparam int PW    = WW + 8;                   // weight * channel
    localparam int SW    = 2 * FRAC_BITS + 10;       // blended sum width

    // config registers
    logic [9:0] sw_reg, sh_reg, tw_reg, th_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= 10'd512;
            sh_reg <= 10'd512;
            tw_reg <= 10'd512;
            th_reg <= 10'd512;
        end
        else if (cfg_we)
        begin
            case (bis_pkg::reg_idx_t'(cfg_index))
                bis_pkg::REG_SRC_W: sw_reg <= cfg_data;
                bis_pkg::REG_SRC_H: sh_reg <= cfg_data;
                bis_pkg::REG_TGT_W: tw_reg <= cfg_data;
                bis_pkg::REG_TGT_H: th_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective dimension: zero reads as one, saturate at max
    function automatic logic [DB-1:0] eff(input logic [9:0] v, input int mx);
        logic [DB-1:0] r;
        begin
            if (v == 10'd0)
                r = DB'(1);
            else if (32'(v) > mx)
                r = DB'(mx);
            else
                r = DB'(v);
            return r;
        end
    endfunction

    logic [DB-1:0] sw_e, sh_e, tw_e, th_e;
    assign sw_e = eff(sw_reg, MAX_DIM_X);
    assign sh_e = eff(sh_reg, MAX_DIM_Y);
    assign tw_e = eff(tw_reg, MAX_DIM_X);
    assign th_e = eff(th_reg, MAX_DIM_Y);

    // pixel memory, one port
    logic [23:0] mem [DEPTH];
    logic [23:0] rd_data_reg;
    logic [AW-1:0] mem_addr;
    logic          mem_we;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= {in_data.in_red, in_data.in_green, in_data.in_blue};
        rd_data_reg <= mem[mem_addr];
    end

    // sequencer registers
    bis_pkg::state_t state_reg, state_next;
    logic [8:0]  px_reg, py_reg;
    logic [1:0]  k_reg, k_next;                 // neighbour step, divider phase
    logic [CB+FRAC_BITS-1:0] cx_reg, cy_reg;
    logic [23:0] pix_reg [4];
    logic [SW-1:0] acc_reg [3];
    logic [WW-1:0] wx_reg, wy_reg;
    logic [2*WW-1:0] w_reg;                     // product of two weights
    bis_pkg::out_word_t out_reg;
    logic out_valid_reg;

    // divider
    logic div_start;
    logic [NUM_W-1:0] div_num, div_q;
    logic [DB-1:0] div_den;
    bis_pkg::div_ctl_t div_ctl;

    bis_divider #(.NUM_W(NUM_W), .DEN_W(DB)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .numer(div_num), .denom(div_den), .ctl(div_ctl), .quot(div_q)
    );

    // coordinate clamp and numerator
    logic [DB-1:0] c_x, c_y;
    assign c_x = ({1'b0, px_reg} > DB'(tw_e - 1'b1)) ? DB'(tw_e - 1'b1) : DB'(px_reg);
    assign c_y = ({1'b0, py_reg} > DB'(th_e - 1'b1)) ? DB'(th_e - 1'b1) : DB'(py_reg);

    logic [NUM_W-1:0] num_x, num_y;
    assign num_x = NUM_W'({DB'(sw_e - 1'b1), {FRAC_BITS{1'b0}}}) * NUM_W'(c_x);
    assign num_y = NUM_W'({DB'(sh_e - 1'b1), {FRAC_BITS{1'b0}}}) * NUM_W'(c_y);

    // neighbour coordinates
    logic [CB-1:0] x0, y0, x1, y1;
    logic [FRAC_BITS-1:0] fx, fy;
    assign x0 = cx_reg[CB+FRAC_BITS-1:FRAC_BITS];
    assign y0 = cy_reg[CB+FRAC_BITS-1:FRAC_BITS];
    assign fx = cx_reg[FRAC_BITS-1:0];
    assign fy = cy_reg[FRAC_BITS-1:0];
    assign x1 = (DB'(x0) + 1'b1 < sw_e) ? CB'(x0 + 1'b1) : CB'(sw_e - 1'b1);
    assign y1 = (DB'(y0) + 1'b1 < sh_e) ? CB'(y0 + 1'b1) : CB'(sh_e - 1'b1);

    logic [CB-1:0] rx, ry;
    logic [AW-1:0] rd_addr;
    always_comb
    begin
        rx = k_reg[0] ? x1 : x0;
        ry = k_reg[1] ? y1 : y0;
        rd_addr = {ry[YB-1:0], rx[XB-1:0]};
    end

    localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

    // shared multipliers: weight pair, and weight by channel
    logic [2*WW-1:0] wprod;
    assign wprod = wx_reg * wy_reg;
    logic [PW+WW-1:0] cprod [3];
    always_comb
    begin
        for (int c = 0; c < 3; c++)
            cprod[c] = w_reg * (2*WW)'(pix_reg[k_reg][8*(2-c) +: 8]);
    end

    logic in_fire, out_fire;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        div_num    = num_x;
        div_den    = DB'(tw_e - 1'b1);
        mem_we     = 1'b0;
        mem_addr   = rd_addr;
        case (state_reg)
            bis_pkg::ST_IDLE:
            begin
                in_ready = !out_valid_reg || out_ready;
                mem_addr = {YB'(in_data.pos_y), XB'(in_data.pos_x)};
                if (in_fire)
                begin
                    if (in_data.cmd == bis_pkg::CMD_WRITE)
                        mem_we = (32'(in_data.pos_x) < MAX_DIM_X)
                              && (32'(in_data.pos_y) < MAX_DIM_Y);
                    else
                        state_next = bis_pkg::ST_DIVX;
                end
            end
            bis_pkg::ST_DIVX:
            begin
                // first cycle launches, then wait for completion
                if (!div_ctl.busy && k_reg == 2'd0)
                begin
                    div_start = (tw_e > DB'(1));
                    k_next = 2'd1;
                    if (tw_e <= DB'(1))
                        k_next = 2'd2;
                end
                else if (!div_ctl.busy)
                begin
                    k_next = 2'd0;
                    state_next = bis_pkg::ST_DIVY;
                end
            end
            bis_pkg::ST_DIVY:
            begin
                div_num = num_y;
                div_den = DB'(th_e - 1'b1);
                if (!div_ctl.busy && k_reg == 2'd0)
                begin
                    div_start = (th_e > DB'(1));
                    k_next = (th_e > DB'(1)) ? 2'd1 : 2'd2;
                end
                else if (!div_ctl.busy)
                begin
                    k_next = 2'd0;
                    state_next = bis_pkg::ST_ADDR;
                end
            end
            bis_pkg::ST_ADDR:
                state_next = bis_pkg::ST_RD;       // read issued for k
            bis_pkg::ST_RD:
            begin
                k_next = k_reg + 1'b1;
                state_next = (k_reg == 2'd3) ? bis_pkg::ST_WX : bis_pkg::ST_ADDR;
            end
            bis_pkg::ST_WX: state_next = bis_pkg::ST_MX;
            bis_pkg::ST_MX: state_next = bis_pkg::ST_WY;
            bis_pkg::ST_WY: state_next = bis_pkg::ST_MY;
            bis_pkg::ST_MY: state_next = bis_pkg::ST_SUM;
            bis_pkg::ST_SUM:
            begin
                k_next = k_reg + 1'b1;
                state_next = (k_reg == 2'd3) ? bis_pkg::ST_OUT : bis_pkg::ST_WX;
            end
            bis_pkg::ST_OUT:
                state_next = bis_pkg::ST_IDLE;
            default:
                state_next = bis_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bis_pkg::ST_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (state_reg == bis_pkg::ST_OUT)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            px_reg <= in_data.pos_x;
            py_reg <= in_data.pos_y;
        end
        case (state_reg)
            bis_pkg::ST_DIVX:
                if (!div_ctl.busy && k_reg != 2'd0)
                    cx_reg <= (k_reg == 2'd2) ? '0 : div_q[CB+FRAC_BITS-1:0];
            bis_pkg::ST_DIVY:
                if (!div_ctl.busy && k_reg != 2'd0)
                    cy_reg <= (k_reg == 2'd2) ? '0 : div_q[CB+FRAC_BITS-1:0];
            bis_pkg::ST_RD:
            begin
                pix_reg[k_reg] <= rd_data_reg;
                for (int c = 0; c < 3; c++)
                    acc_reg[c] <= SW'(1) << (2*FRAC_BITS - 1);
            end
            bis_pkg::ST_WX:
            begin
                wx_reg <= k_reg[0] ? WW'(fx) : ONE - WW'(fx);
                wy_reg <= k_reg[1] ? WW'(fy) : ONE - WW'(fy);
            end
            bis_pkg::ST_MX:
                w_reg <= wprod;
            bis_pkg::ST_SUM:
            begin
                for (int c = 0; c < 3; c++)
                    acc_reg[c] <= acc_reg[c] + SW'(cprod[c]);
            end
            bis_pkg::ST_OUT:
            begin
                out_reg.out_red   <= acc_reg[0][2*FRAC_BITS +: 8];
                out_reg.out_green <= acc_reg[1][2*FRAC_BITS +: 8];
                out_reg.out_blue  <= acc_reg[2][2*FRAC_BITS +: 8];
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // never take a new word while busy computing
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != bis_pkg::ST_IDLE) |-> !in_ready)
        else $error("input accepted while busy");

    // a finished result is always registered as valid next cycle
    a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bis_pkg::ST_OUT) |=> out_valid)
        else $error("result lost");

    // memory written only from idle
    a_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == bis_pkg::ST_IDLE && in_fire))
        else $error("stray memory write");
endmodule

### hdl/bis_divider.sv
// Restoring divider, one quotient bit per cycle.
module bis_divider #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 13
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_W-1:0]     numer,
    input  logic [DEN_W-1:0]     denom,
    output bis_pkg::div_ctl_t    ctl,
    output logic [NUM_W-1:0]     quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    assign trial = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end
        else if (busy_reg)
        begin
            if (!diff[DEN_W])
            begin
                rem_reg <= diff;
                q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign quot      = q_reg;
endmodule

### tb/bilinear_image_scaler_core_tb.sv
`timescale 1ns / 1ps

module bilinear_image_scaler_core_tb;

    localparam int DIM_X = 512;
    localparam int DIM_Y = 512;
    localparam int FRAC = 16;
    localparam int SETTLE_CYCLES = 200;   // > one full compute, for config pauses and the end
    localparam int STALL_LIMIT = 20000;   // cycles with no word moving on either side

    // Golden pixel model: tracks the image, the dimension registers and the
    // queue of interpolated pixels still owed by the block.
    class scaler_scoreboard;
        bit [23:0]            image_px [int];
        int unsigned          dim_reg [bis_pkg::NUM_REGS];
        bis_pkg::out_word_t   pixel_q [$];
        int                   errors;

        function new();
            foreach (dim_reg[i])
                dim_reg[i] = 512;
            errors = 0;
        endfunction

        function void set_reg(bis_pkg::reg_idx_t idx, logic [bis_pkg::REG_W-1:0] value);
            dim_reg[idx] = value;
        endfunction

        function bit has_pixel(int unsigned x, int unsigned y);
            return image_px.exists(y * DIM_X + x);
        endfunction

        // zero reads as one, oversize saturates
        function int unsigned clip_dim(int unsigned v, int unsigned maxv);
            if (v == 0)
                return 1;
            if (v > maxv)
                return maxv;
            return v;
        endfunction

        // target coordinate -> source fixed point, truncated
        function longint unsigned src_coord(int unsigned s, int unsigned t, int unsigned c);
            if (t <= 1)
                return 0;
            if (c > t - 1)
                c = t - 1;
            return ((longint'(s - 1) << FRAC) * c) / (t - 1);
        endfunction

        // neighbor grid and fractions for a target pixel
        function void locate(input int unsigned px, input int unsigned py,
                             output int unsigned x0, output int unsigned x1,
                             output int unsigned y0, output int unsigned y1,
                             output longint unsigned fx, output longint unsigned fy);
            int unsigned sw, sh;
            longint unsigned cx, cy;
            sw = clip_dim(dim_reg[bis_pkg::REG_SRC_W], DIM_X);
            sh = clip_dim(dim_reg[bis_pkg::REG_SRC_H], DIM_Y);
            cx = src_coord(sw, clip_dim(dim_reg[bis_pkg::REG_TGT_W], DIM_X), px);
            cy = src_coord(sh, clip_dim(dim_reg[bis_pkg::REG_TGT_H], DIM_Y), py);
            x0 = 32'(cx >> FRAC);
            y0 = 32'(cy >> FRAC);
            fx = cx & ((64'd1 << FRAC) - 1);
            fy = cy & ((64'd1 << FRAC) - 1);
            x1 = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
            y1 = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
        endfunction

        function logic [7:0] mix(logic [7:0] c1, logic [7:0] c2, logic [7:0] c3,
                                 logic [7:0] c4, longint unsigned fx, longint unsigned fy);
            longint unsigned one, acc;
            one = 64'd1 << FRAC;
            acc = (one - fx) * (one - fy) * c1 + fx * (one - fy) * c2
                + (one - fx) * fy * c3 + fx * fy * c4;
            acc += 64'd1 << (2 * FRAC - 1);
            return 8'(acc >> (2 * FRAC));
        endfunction

        function void note_input(bis_pkg::in_word_t w);
            int unsigned x0, x1, y0, y1;
            longint unsigned fx, fy;
            bit [23:0] p1, p2, p3, p4;
            bis_pkg::out_word_t px_out;
            if (w.cmd == bis_pkg::CMD_WRITE) begin
                image_px[w.pos_y * DIM_X + w.pos_x] = {w.in_red, w.in_green, w.in_blue};
                return;
            end
            locate(w.pos_x, w.pos_y, x0, x1, y0, y1, fx, fy);
            p1 = image_px[y0 * DIM_X + x0];
            p2 = image_px[y0 * DIM_X + x1];
            p3 = image_px[y1 * DIM_X + x0];
            p4 = image_px[y1 * DIM_X + x1];
            px_out.out_red   = mix(p1[23:16], p2[23:16], p3[23:16], p4[23:16], fx, fy);
            px_out.out_green = mix(p1[15:8], p2[15:8], p3[15:8], p4[15:8], fx, fy);
            px_out.out_blue  = mix(p1[7:0], p2[7:0], p3[7:0], p4[7:0], fx, fy);
            pixel_q.push_back(px_out);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(bis_pkg::out_word_t got);
            bis_pkg::out_word_t want;
            if (pixel_q.size() == 0) begin
                report($sformatf("unexpected pixel %h", got));
                return;
            end
            want = pixel_q.pop_front();
            if (got.out_red !== want.out_red)
                report($sformatf("red %h, want %h", got.out_red, want.out_red));
            if (got.out_green !== want.out_green)
                report($sformatf("green %h, want %h", got.out_green, want.out_green));
            if (got.out_blue !== want.out_blue)
                report($sformatf("blue %h, want %h", got.out_blue, want.out_blue));
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    bis_pkg::in_word_t              in_data;
    logic                           out_valid;
    logic                           out_ready;
    bis_pkg::out_word_t             out_data;
    logic                           cfg_we;
    logic [1:0]                     cfg_index;
    logic [bis_pkg::REG_W-1:0]      cfg_data;

    scaler_scoreboard sb = new();
    int send_pct;      // chance per cycle the sender holds off
    int stall_pct;     // chance per cycle the receiver stalls
    int quiet_cycles;

    bilinear_image_scaler_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: sample at the edge (pre-update values), then pick the
    // next ready. Also the watchdog on forward progress.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            quiet_cycles = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                sb.check_result(out_data);
            out_ready <= ($urandom_range(99) >= stall_pct);
            if ((out_valid && out_ready) || (in_valid && in_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("** bilinear_image_scaler_core: FAILED **");
                $finish;
            end
        end
    end

    // One input word: optional hold-off, then valid held until accepted.
    task send_word(bis_pkg::in_word_t w);
        while ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(w);
    endtask

    task write_pixel(int unsigned x, int unsigned y, logic [23:0] rgb);
        bis_pkg::in_word_t w;
        w.cmd      = bis_pkg::CMD_WRITE;
        w.pos_x    = 9'(x);
        w.pos_y    = 9'(y);
        w.in_red   = rgb[23:16];
        w.in_green = rgb[15:8];
        w.in_blue  = rgb[7:0];
        send_word(w);
    endtask

    // Compute a target pixel; any neighbor not yet in memory is written
    // first, so the block never reads an uninitialized entry.
    task compute_pixel(int unsigned px, int unsigned py);
        int unsigned x0, x1, y0, y1;
        longint unsigned fx, fy;
        bis_pkg::in_word_t w;
        sb.locate(px, py, x0, x1, y0, y1, fx, fy);
        if (!sb.has_pixel(x0, y0))
            write_pixel(x0, y0, 24'($urandom()));
        if (!sb.has_pixel(x1, y0))
            write_pixel(x1, y0, 24'($urandom()));
        if (!sb.has_pixel(x0, y1))
            write_pixel(x0, y1, 24'($urandom()));
        if (!sb.has_pixel(x1, y1))
            write_pixel(x1, y1, 24'($urandom()));
        w = '0;
        {w.in_red, w.in_green, w.in_blue} = 24'($urandom());   // ignored on compute
        w.cmd   = bis_pkg::CMD_COMPUTE;
        w.pos_x = 9'(px);
        w.pos_y = 9'(py);
        send_word(w);
    endtask

    // Drain all owed pixels, then let a trailing write finish.
    task wait_drained();
        in_valid <= 1'b0;
        while (sb.pixel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task set_dims(logic [bis_pkg::REG_W-1:0] sw, logic [bis_pkg::REG_W-1:0] sh,
                  logic [bis_pkg::REG_W-1:0] tw, logic [bis_pkg::REG_W-1:0] th);
        bis_pkg::reg_idx_t idx;
        logic [bis_pkg::REG_W-1:0] vals [bis_pkg::NUM_REGS];
        vals = '{sw, sh, tw, th};
        wait_drained();
        for (int i = 0; i < bis_pkg::NUM_REGS; i++)
        begin
            idx = bis_pkg::reg_idx_t'(i);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[i];
            sb.set_reg(idx, vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly computes (neighbors filled, some coordinates out of range), some stray writes.
    task random_phase(int n_words);
        int unsigned tw, th, px, py;
        for (int i = 0; i < n_words; i++)
        begin
            if (i == n_words / 2)
            begin
                // hold off until the block has delivered everything owed
                in_valid <= 1'b0;
                while (sb.pixel_q.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            if ($urandom_range(99) < 75)
            begin
                tw = sb.clip_dim(sb.dim_reg[bis_pkg::REG_TGT_W], DIM_X);
                th = sb.clip_dim(sb.dim_reg[bis_pkg::REG_TGT_H], DIM_Y);
                px = ($urandom_range(9) < 7) ? $urandom_range(tw - 1) : $urandom_range(511);
                py = ($urandom_range(9) < 7) ? $urandom_range(th - 1) : $urandom_range(511);
                compute_pixel(px, py);
            end
            else
                write_pixel($urandom_range(511), $urandom_range(511), 24'($urandom()));
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= bis_pkg::REG_SRC_W;
        cfg_data  <= '0;
        send_pct  = 0;
        stall_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset dimensions (identity 512 -> 512): corners, color extremes
        write_pixel(0, 0, 24'hFFFFFF);
        write_pixel(1, 0, 24'h000000);
        write_pixel(0, 1, 24'hFF00FF);
        write_pixel(1, 1, 24'h00FF00);
        write_pixel(511, 511, 24'h000000);
        write_pixel(511, 510, 24'hFFFFFF);
        write_pixel(510, 511, 24'h80FF01);
        write_pixel(510, 510, 24'h7F0080);
        write_pixel(511, 0, 24'hAA55AA);
        write_pixel(0, 511, 24'h55AA55);
        compute_pixel(0, 0);
        compute_pixel(511, 511);
        compute_pixel(510, 510);
        compute_pixel(511, 0);
        compute_pixel(0, 511);
        compute_pixel(255, 256);

        // zero registers read as one: everything lands on (0,0)
        set_dims(0, 0, 0, 0);
        send_pct = 62;
        compute_pixel(0, 0);
        compute_pixel(511, 511);
        random_phase(100);

        // oversize saturates; target size one maps to coordinate zero
        set_dims(1023, 1023, 1, 1);
        send_pct = 0; stall_pct = 62;
        compute_pixel(511, 511);
        random_phase(100);

        set_dims(4, 3, 9, 7);            // upscale
        send_pct = 36; stall_pct = 36;
        random_phase(110);

        set_dims(16, 16, 5, 5);          // downscale
        send_pct = 0; stall_pct = 0;
        random_phase(110);

        set_dims(512, 512, 512, 512);
        send_pct = 62; stall_pct = 0;
        random_phase(100);

        set_dims(1, 8, 8, 1);
        send_pct = 0; stall_pct = 62;
        random_phase(100);

        set_dims(512, 2, 3, 512);
        send_pct = 36; stall_pct = 36;
        random_phase(100);

        set_dims(10'($urandom_range(2, 12)), 10'($urandom_range(2, 12)),
                 10'($urandom_range(2, 12)), 10'($urandom_range(2, 12)));
        send_pct = 0; stall_pct = 0;
        random_phase(110);

        set_dims(7, 7, 7, 7);
        send_pct = 62; stall_pct = 62;
        random_phase(110);

        wait_drained();
        if (sb.errors == 0 && sb.pixel_q.size() == 0)
            $display("** bilinear_image_scaler_core: PASSED **");
        else
            $display("** bilinear_image_scaler_core: FAILED **");
        $finish;
    end

endmodule

### files.f
hdl/bis_pkg.sv
hdl/bis_divider.sv
hdl/bilinear_image_scaler_core.sv
tb/bilinear_image_scaler_core_tb.sv
